// ===== src/differential_drive_odometry_assert.svh =====
// Assertion macros for the odometry RTL.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDO_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DDO_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ddo_pkg.sv =====
package ddo_pkg;

  localparam int TRIG_STEPS_DEF = 16;
  localparam int ANGLE_BITS_DEF = 16;

  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30_34   = 34'sd1073741824;
  localparam logic [31:0]        PI_Q29       = 32'd1686629713;
  localparam logic [31:0]        INV_PI_Q32   = 32'd1367130551;
  localparam logic [63:0]        SERIES_LIMIT = 64'h0000_0000_0800_0000;

  // Reciprocals for exact division by 6 (operand below 2^24, shift 27) and
  // by 120 (operand below 2^18, shift 25).
  localparam logic [31:0]        RECIP_6      = 32'd22369622;
  localparam logic [31:0]        RECIP_120    = 32'd279621;

  localparam logic [23:0] DPT_RESET = 24'd56361;
  localparam logic [31:0] APT_RESET = 32'd2877000;

  localparam int  CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DPT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_APT = 1'b1;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
    logic signed [33:0] r;
    if (v > ONE_Q30_34) begin
      r = ONE_Q30_34;
    end else if (v < -ONE_Q30_34) begin
      r = -ONE_Q30_34;
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

endpackage

// ===== src/ddo_cordic.sv =====
module ddo_cordic import ddo_pkg::*; #(
  parameter int TRIG_STEPS = TRIG_STEPS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        angle_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  localparam int IW = $clog2(TRIG_STEPS);
  localparam logic [31:0] MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  logic              busy_q, busy_d, done_q, done_d, flip_q, flip_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [31:0]       t, tw, tf;
  logic signed [33:0] xs, ys, at, xo, yo;

  always_comb begin
    t  = angle_i & MASK;
    tw = t + 32'h4000_0000;
    tf = tw[31] ? t + 32'h8000_0000 : t;
    xs = x_q >>> idx_q;
    ys = y_q >>> idx_q;
    at = $signed({2'b00, atan_turn(5'(idx_q))});
    busy_d = busy_q;
    done_d = 1'b0;
    idx_d  = idx_q;
    flip_d = flip_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      flip_d = tw[31];
      x_d = CORDIC_START;
      y_d = '0;
      z_d = $signed({{2{tf[31]}}, tf});
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
      idx_d = idx_q + IW'(1);
      if (idx_q == IW'(TRIG_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
    xo = flip_q ? -x_q : x_q;
    yo = flip_q ? -y_q : y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flip_q <= flip_d;
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign cos_o  = clamp_unit(xo);
  assign sin_o  = clamp_unit(yo);

endmodule

// ===== src/ddo_div.sv =====
module ddo_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d, q_q, q_d, den_q, den_d;
  logic [64:0] r, rs;
  logic        ge;

  always_comb begin
    r  = {rem_q, q_q[63]};
    ge = r >= {1'b0, den_q};
    rs = r - {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    q_d    = q_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      q_d    = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? rs[63:0] : r[63:0];
      q_d   = {q_q[62:0], ge};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    q_q   <= q_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

// ===== src/differential_drive_odometry.sv =====
// Differential-drive wheel odometry. Each item on the slave stream carries the two absolute
// encoder counts and a kind bit; every item returns one pose item on the master stream. An
// init item goes from idle straight to the output step. An update item runs the CORDIC, the
// divider and the CORDIC again when the heading change is large, a short series and then the
// CORDIC when it is small (the chord factor then comes from that series, whose divisions by
// constants are reciprocal multiplications) and the CORDIC alone when it is zero; the 64-step
// restoring divider and the CORDIC iterations dominate its run time, and one 33x32 multiplier
// serves every product in turn. The block takes the next item while a finished pose still
// waits on the output, and holds that item in its last step until the output is free.
module differential_drive_odometry import ddo_pkg::*; #(
  parameter int TRIG_STEPS = TRIG_STEPS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,  // left_count, right_count
  input  logic                 s_axis_tuser,  // kind
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [79:0]          m_axis_tdata   // pose_x, pose_y, pose_heading
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_MAG = 5'd1,  S_LEN = 5'd2,  S_BR = 5'd3,
                         S_HQ = 5'd4,    S_H2 = 5'd5,   S_H4 = 5'd6,   S_D6 = 5'd7,
                         S_D120 = 5'd8,  S_CS = 5'd9,   S_SQ = 5'd10,  S_SD = 5'd11,
                         S_CP = 5'd12,   S_LC = 5'd13,  S_DX = 5'd14,  S_DY = 5'd15,
                         S_FY = 5'd16,   S_MQ1 = 5'd17, S_MQ2 = 5'd18, S_WC = 5'd19,
                         S_WD = 5'd20,   S_DONE = 5'd21;

  localparam logic signed [31:0] C_MAX = 32'sd1073741824;
  localparam logic signed [31:0] C_MIN = -32'sd1073741824;

  logic [4:0]  state_q, state_d, ret_q, ret_d;
  logic        out_valid_q, out_valid_d, upd_q, upd_d;
  logic [23:0] dpt_q, dpt_d;
  logic [31:0] apt_q, apt_d, prev_l_q, prev_l_d, prev_r_q, prev_r_d;
  logic signed [31:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d, nx_q, nx_d, ny_q, ny_d;
  logic signed [31:0] c_q, c_d;
  logic [15:0] head_q, head_d;
  logic [32:0] dmag_q, dmag_d, smag_q, smag_d;
  logic        dneg_q, dneg_d, sneg_q, sneg_d, shneg_q, shneg_d;
  logic [63:0] mag_q, mag_d;
  logic [47:0] lq8_q, lq8_d, mq_a_q, mq_a_d, res_q, res_d, lc_mag_q, lc_mag_d;
  logic [30:0] mq_b_q, mq_b_d;
  logic        mq_neg_q, mq_neg_d, lc_neg_q, lc_neg_d;
  logic [48:0] acc_q, acc_d;
  logic [26:0] tmp_q, tmp_d;
  logic [17:0] tmp2_q, tmp2_d;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;
  logic        cor_start, cor_done, div_start, div_done;
  logic [31:0] cor_angle;
  logic signed [31:0] cor_cos, cor_sin, sq;
  logic [63:0] div_num, div_den, div_quot;
  logic [31:0] dl, dr, half;
  logic [32:0] diff, sum;
  logic [31:0] sin_mag, cos_mag, c_mag, qc;
  logic signed [49:0] delta, sat_x, sat_y;
  logic [15:0] turn;
  logic        acc_in;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign prod = {32'b0, mul_a} * {33'b0, mul_b};

  ddo_cordic #(.TRIG_STEPS(TRIG_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cor_start), .angle_i(cor_angle),
    .done_o(cor_done), .cos_o(cor_cos), .sin_o(cor_sin)
  );

  ddo_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot)
  );

  always_comb begin
    acc_in  = s_axis_tvalid && s_axis_tready;
    dl      = s_axis_tdata[31:0] - prev_l_q;
    dr      = s_axis_tdata[63:32] - prev_r_q;
    diff    = {dr[31], dr} - {dl[31], dl};
    sum     = {dr[31], dr} + {dl[31], dl};
    half    = dneg_q ? 32'd0 - mag_q[32:1] : mag_q[32:1];
    turn    = mag_q[31:16] + {15'd0, mag_q[15]};
    sin_mag = cor_sin[31] ? 32'd0 - cor_sin : cor_sin;
    cos_mag = cor_cos[31] ? 32'd0 - cor_cos : cor_cos;
    c_mag   = c_q[31] ? 32'd0 - c_q : c_q;
    qc      = (div_quot > 64'h4000_0000) ? 32'h4000_0000 : div_quot[31:0];
    delta   = mq_neg_q ? -$signed({2'b00, res_q}) : $signed({2'b00, res_q});
    sat_x   = $signed({{18{pos_x_q[31]}}, pos_x_q}) + delta;
    sat_y   = $signed({{18{pos_y_q[31]}}, pos_y_q}) + delta;
    sq      = c_q + $signed({16'b0, prod[40:25]});

    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MAG:   begin mul_a = dmag_q; mul_b = apt_q; end
      S_LEN:   begin mul_a = smag_q; mul_b = {8'b0, dpt_q}; end
      S_HQ:    begin mul_a = mag_q[32:0]; mul_b = PI_Q29; end
      S_H2, S_H4: begin mul_a = {6'b0, tmp_q}; mul_b = {5'b0, tmp_q}; end
      S_D6:    begin mul_a = {6'b0, tmp_q}; mul_b = RECIP_6; end
      S_D120:  begin mul_a = {15'b0, tmp2_q}; mul_b = RECIP_120; end
      S_SQ:    begin mul_a = {1'b0, sin_mag}; mul_b = INV_PI_Q32; end
      S_MQ1:   begin mul_a = {15'b0, mq_a_q[47:30]}; mul_b = {1'b0, mq_b_q}; end
      S_MQ2:   begin mul_a = {3'b0, mq_a_q[29:0]}; mul_b = {1'b0, mq_b_q}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase

    cor_start = (state_q == S_CS) || (state_q == S_CP);
    cor_angle = (state_q == S_CS) ? mag_q[32:1] : {head_q, 16'b0} + half;
    div_start = (state_q == S_SQ);
    div_num   = prod[63:0];
    div_den   = mag_q;

    state_d = state_q;  ret_d = ret_q;  out_valid_d = out_valid_q;  upd_d = upd_q;
    dpt_d = dpt_q;  apt_d = apt_q;  prev_l_d = prev_l_q;  prev_r_d = prev_r_q;
    pos_x_d = pos_x_q;  pos_y_d = pos_y_q;  head_d = head_q;  nx_d = nx_q;  ny_d = ny_q;
    c_d = c_q;  dmag_d = dmag_q;  smag_d = smag_q;  dneg_d = dneg_q;  sneg_d = sneg_q;
    shneg_d = shneg_q;  mag_d = mag_q;  lq8_d = lq8_q;  mq_a_d = mq_a_q;  mq_b_d = mq_b_q;
    mq_neg_d = mq_neg_q;  res_d = res_q;  lc_mag_d = lc_mag_q;  lc_neg_d = lc_neg_q;
    acc_d = acc_q;  tmp_d = tmp_q;  tmp2_d = tmp2_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DPT: dpt_d = cfg_data_i[23:0];
        REG_APT: apt_d = cfg_data_i;
        default: apt_d = apt_q;
      endcase
    end
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (acc_in) begin
          dneg_d   = diff[32];
          dmag_d   = diff[32] ? 33'd0 - diff : diff;
          sneg_d   = sum[32];
          smag_d   = sum[32] ? 33'd0 - sum : sum;
          prev_l_d = s_axis_tdata[31:0];
          prev_r_d = s_axis_tdata[63:32];
          upd_d    = s_axis_tuser;
          state_d  = s_axis_tuser ? S_MAG : S_DONE;
        end
      end
      S_MAG: begin mag_d = prod[63:0]; state_d = S_LEN; end
      S_LEN: begin lq8_d = prod[56:9]; state_d = S_BR; end
      S_BR: begin
        if (mag_q == 64'd0) begin
          c_d = C_MAX;
          state_d = S_CP;
        end else if (mag_q < SERIES_LIMIT) begin
          state_d = S_HQ;
        end else begin
          state_d = S_CS;
        end
      end
      S_HQ: begin tmp_d = prod[57:31]; state_d = S_H2; end
      S_H2: begin tmp_d = {3'b0, prod[53:30]}; state_d = S_H4; end
      S_H4: begin tmp2_d = prod[47:30]; state_d = S_D6; end
      S_D6: begin c_d = C_MAX - $signed({8'b0, prod[50:27]}); state_d = S_D120; end
      S_D120: begin c_d = (sq > C_MAX) ? C_MAX : sq; state_d = S_CP; end
      S_CS: begin ret_d = S_SQ; state_d = S_WC; end
      S_SQ: begin shneg_d = cor_sin[31]; ret_d = S_SD; state_d = S_WD; end
      S_SD: begin c_d = shneg_q ? 32'd0 - qc : qc; state_d = S_CP; end
      S_CP: begin ret_d = S_LC; state_d = S_WC; end
      S_LC: begin
        mq_a_d = lq8_q;
        mq_b_d = c_mag[30:0];
        mq_neg_d = sneg_q ^ c_q[31];
        ret_d = S_DX;
        state_d = S_MQ1;
      end
      S_DX: begin
        lc_mag_d = res_q;
        lc_neg_d = mq_neg_q;
        mq_a_d = res_q;
        mq_b_d = cos_mag[30:0];
        mq_neg_d = mq_neg_q ^ cor_cos[31];
        ret_d = S_DY;
        state_d = S_MQ1;
      end
      S_DY: begin
        nx_d = sat32(sat_x);
        mq_a_d = lc_mag_q;
        mq_b_d = sin_mag[30:0];
        mq_neg_d = lc_neg_q ^ cor_sin[31];
        ret_d = S_FY;
        state_d = S_MQ1;
      end
      S_FY: begin ny_d = sat32(sat_y); state_d = S_DONE; end
      S_MQ1: begin acc_d = prod[48:0]; state_d = S_MQ2; end
      S_MQ2: begin
        res_d = 48'(acc_q + {18'b0, prod[60:30]});
        state_d = ret_q;
      end
      S_WC: begin
        if (cor_done) begin
          state_d = ret_q;
        end
      end
      S_WD: begin
        if (div_done) begin
          state_d = ret_q;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          if (upd_q) begin
            pos_x_d = nx_q;
            pos_y_d = ny_q;
            head_d  = dneg_q ? head_q - turn : head_q + turn;
          end
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      out_valid_q <= 1'b0;
      upd_q       <= 1'b0;
      dpt_q       <= DPT_RESET;
      apt_q       <= APT_RESET;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      head_q      <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
      upd_q       <= upd_d;
      dpt_q       <= dpt_d;
      apt_q       <= apt_d;
      prev_l_q    <= prev_l_d;
      prev_r_q    <= prev_r_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      head_q      <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q <= nx_d;  ny_q <= ny_d;  c_q <= c_d;  dmag_q <= dmag_d;  smag_q <= smag_d;
    dneg_q <= dneg_d;  sneg_q <= sneg_d;  shneg_q <= shneg_d;  mag_q <= mag_d;
    lq8_q <= lq8_d;  mq_a_q <= mq_a_d;  mq_b_q <= mq_b_d;  mq_neg_q <= mq_neg_d;
    res_q <= res_d;  lc_mag_q <= lc_mag_d;  lc_neg_q <= lc_neg_d;  acc_q <= acc_d;
    tmp_q <= tmp_d;  tmp2_q <= tmp2_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {head_q, pos_y_q, pos_x_q};

`include "differential_drive_odometry_assert.svh"

  `DDO_ASSERT_IMP(a_cor_done, cor_done, state_q == S_WC, "CORDIC finished outside its wait")
  `DDO_ASSERT_IMP(a_div_done, div_done, state_q == S_WD, "divider finished outside its wait")
  `DDO_ASSERT_IMP(a_c_range, state_q == S_LC, (c_q <= C_MAX) && (c_q >= C_MIN), "c out of range")
  `DDO_ASSERT_NXT(a_init, acc_in && !s_axis_tuser, state_q == S_DONE, "init item not direct")

endmodule
